/* rtl/fwspi_pkg.sv */
// ----------------------------------------------------------------------------
// fwspi_pkg: shared types and constants
// Operation codes, register indexes and the command/status structs that
// join the sequencer and the datapath of the four-wheel speed controller.
// ----------------------------------------------------------------------------
package fwspi_pkg;

	localparam int COUNT_WIDTH_DEF = 32;

	// operation codes of an input beat
	localparam logic [2:0] OP_EDGE   = 3'd0;
	localparam logic [2:0] OP_TICK   = 3'd1;
	localparam logic [2:0] OP_LOAD   = 3'd2;
	localparam logic [2:0] OP_BRAKE  = 3'd3;
	localparam logic [2:0] OP_RESET  = 3'd4;
	localparam logic [2:0] OP_STOP   = 3'd5;
	localparam logic [2:0] OP_START  = 3'd6;

	// configuration register indexes
	localparam logic [2:0] REG_PROP      = 3'd0;
	localparam logic [2:0] REG_INTEG     = 3'd1;
	localparam logic [2:0] REG_PAIR_PROP = 3'd2;
	localparam logic [2:0] REG_PAIR_INTEG= 3'd3;
	localparam logic [2:0] REG_RATE      = 3'd4;
	localparam logic [2:0] REG_DEAD_ZONE = 3'd5;

	localparam logic [15:0] RATE_RST = 16'd100;
	localparam logic [7:0]  DUTY_MAX = 8'd255;

	typedef enum logic [1:0] {A_DIFF, A_ERR, A_COUP} a_sel_t;
	typedef enum logic [2:0] {B_RATE, B_IG, B_PIG, B_PG, B_PPG} b_sel_t;
	typedef enum logic [1:0] {ACC_NONE, ACC_INTEG, ACC_OFFSET, ACC_ADD} acc_op_t;
	typedef enum logic [2:0] {
		WR_NONE, WR_ITEM, WR_ERR, WR_PAIR, WR_INTEG, WR_DUTY, WR_FINISH
	} wr_op_t;

	typedef struct packed {
		logic [1:0] wheel;
		logic       diff_en;
		logic       mul_en;
		a_sel_t     a_sel;
		b_sel_t     b_sel;
		acc_op_t    acc_op;
		wr_op_t     wr_op;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       loop_en;
	} status_t;

endpackage

/* rtl/fwspi_in_if.sv */
// ----------------------------------------------------------------------------
// fwspi_in_if: input item channel
// Valid/ready channel carrying one operation beat.
// ----------------------------------------------------------------------------
interface fwspi_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [1:0]  wheel;
	logic [30:0] tick_count;
	logic        direction;
	logic [15:0] target_speed;
	logic        pair_straight;

	modport source (output valid, operation, wheel, tick_count, direction,
		target_speed, pair_straight, input ready);
	modport sink (input valid, operation, wheel, tick_count, direction,
		target_speed, pair_straight, output ready);
endinterface

/* rtl/fwspi_out_if.sv */
// ----------------------------------------------------------------------------
// fwspi_out_if: result channel
// Valid/ready channel carrying duties and wheel status.
// ----------------------------------------------------------------------------
interface fwspi_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] duty_a;
	logic [7:0] duty_b;
	logic [7:0] duty_c;
	logic [7:0] duty_d;
	logic [3:0] running_mask;
	logic [3:0] polarity_mask;
	logic       loop_active;

	modport source (output valid, duty_a, duty_b, duty_c, duty_d, running_mask,
		polarity_mask, loop_active, input ready);
	modport sink (input valid, duty_a, duty_b, duty_c, duty_d, running_mask,
		polarity_mask, loop_active, output ready);
endinterface

/* rtl/fwspi_cfg_if.sv */
// ----------------------------------------------------------------------------
// fwspi_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface fwspi_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/fwspi_ctrl.sv */
// ----------------------------------------------------------------------------
// fwspi_ctrl: sequencer
// Walks one control tick through the shared multiplier wheel by wheel and
// issues single-cycle updates for the other operations.
// ----------------------------------------------------------------------------
module fwspi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               out_ready,
	input  fwspi_pkg::status_t status,
	output logic               in_ready,
	output logic               out_valid,
	output fwspi_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_DIFF, S_SPD, S_ERR, S_PAIR,
		S_I0, S_I1, S_I2, S_I3, S_C0, S_C1, S_C2, S_C3, S_FIN, S_OUT
	} state_t;

	state_t     state_q;
	logic [1:0] wcnt_q;
	logic       in_ready_q;
	logic       out_valid_q;

	// state, wheel counter and handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wcnt_q      <= 2'd0;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q    <= S_DECODE;
						in_ready_q <= 1'b0;
					end
				end
				S_DECODE: begin
					wcnt_q <= 2'd0;
					if (status.op == fwspi_pkg::OP_TICK && status.loop_en) begin
						state_q <= S_DIFF;
					end else begin
						state_q     <= S_OUT;
						out_valid_q <= 1'b1;
					end
				end
				S_DIFF: state_q <= S_SPD;
				S_SPD:  state_q <= S_ERR;
				S_ERR: begin
					wcnt_q <= wcnt_q + 2'd1;
					state_q <= (wcnt_q == 2'd3) ? S_PAIR : S_DIFF;
				end
				S_PAIR: state_q <= S_I0;
				S_I0:   state_q <= S_I1;
				S_I1:   state_q <= S_I2;
				S_I2:   state_q <= S_I3;
				S_I3:   state_q <= S_C0;
				S_C0:   state_q <= S_C1;
				S_C1:   state_q <= S_C2;
				S_C2:   state_q <= S_C3;
				S_C3: begin
					wcnt_q <= wcnt_q + 2'd1;
					state_q <= (wcnt_q == 2'd3) ? S_FIN : S_I0;
				end
				S_FIN: begin
					state_q     <= S_OUT;
					out_valid_q <= 1'b1;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd         = '0;
		cmd.wheel   = wcnt_q;
		cmd.a_sel   = fwspi_pkg::A_DIFF;
		cmd.b_sel   = fwspi_pkg::B_RATE;
		cmd.acc_op  = fwspi_pkg::ACC_NONE;
		cmd.wr_op   = fwspi_pkg::WR_NONE;
		unique case (state_q)
			S_DECODE: begin
				if (status.op != fwspi_pkg::OP_TICK) cmd.wr_op = fwspi_pkg::WR_ITEM;
			end
			S_DIFF: cmd.diff_en = 1'b1;
			S_SPD:  cmd.mul_en  = 1'b1;
			S_ERR:  cmd.wr_op   = fwspi_pkg::WR_ERR;
			S_PAIR: cmd.wr_op   = fwspi_pkg::WR_PAIR;
			S_I0: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel  = fwspi_pkg::A_ERR;
				cmd.b_sel  = fwspi_pkg::B_IG;
			end
			S_I1: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel  = fwspi_pkg::A_COUP;
				cmd.b_sel  = fwspi_pkg::B_PIG;
				cmd.acc_op = fwspi_pkg::ACC_INTEG;
			end
			S_I2: cmd.acc_op = fwspi_pkg::ACC_ADD;
			S_I3: cmd.wr_op  = fwspi_pkg::WR_INTEG;
			S_C0: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel  = fwspi_pkg::A_ERR;
				cmd.b_sel  = fwspi_pkg::B_PG;
			end
			S_C1: begin
				cmd.mul_en = 1'b1;
				cmd.a_sel  = fwspi_pkg::A_COUP;
				cmd.b_sel  = fwspi_pkg::B_PPG;
				cmd.acc_op = fwspi_pkg::ACC_OFFSET;
			end
			S_C2:  cmd.acc_op = fwspi_pkg::ACC_ADD;
			S_C3:  cmd.wr_op  = fwspi_pkg::WR_DUTY;
			S_FIN: cmd.wr_op  = fwspi_pkg::WR_FINISH;
			default: ;
		endcase
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

/* rtl/fwspi_dp.sv */
// ----------------------------------------------------------------------------
// fwspi_dp: datapath
// Wheel state, configuration registers, one shared signed multiplier and an
// accumulator; wheel and scratch updates are steered by the sequencer's command.
// ----------------------------------------------------------------------------
module fwspi_dp #(
	parameter int COUNT_WIDTH = fwspi_pkg::COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fwspi_pkg::cmd_t    cmd,
	output fwspi_pkg::status_t status,
	input  logic               item_load,
	input  logic [2:0]         operation,
	input  logic [1:0]         wheel,
	input  logic [30:0]        tick_count,
	input  logic               direction,
	input  logic [15:0]        target_speed,
	input  logic               pair_straight,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic [7:0]         duty_a,
	output logic [7:0]         duty_b,
	output logic [7:0]         duty_c,
	output logic [7:0]         duty_d,
	output logic [3:0]         running_mask,
	output logic [3:0]         polarity_mask,
	output logic               loop_active
);

	localparam int CW = COUNT_WIDTH;
	localparam int DW = 41;                     // clamped difference / error
	localparam int XW = (CW > DW) ? CW : DW;
	localparam int PW = DW + 17;                // product
	localparam int EW = PW + 1;
	localparam int AW = PW + 3;                 // accumulator
	localparam logic signed [DW-1:0] LIM   = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [XW-1:0] LIM_X = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [EW-1:0] LIM_E = {{(EW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [AW-1:0] ISAT_LO = -(AW'(64'sd2147483648));
	localparam logic signed [AW-1:0] CMD_MAX = AW'(32'sd65280);
	localparam logic [7:0] DUTY_MAX_C = fwspi_pkg::DUTY_MAX;

	// configuration
	logic [15:0] pg_q, ig_q, ppg_q, pig_q, rate_q;
	logic [31:0] dz_q;

	// item
	logic [2:0]  op_q;
	logic [1:0]  wh_q;
	logic [30:0] tick_q;
	logic        dir_q, ps_q;
	logic [15:0] tgt_q;

	// wheel state
	logic [CW-1:0]        rem_q  [4];
	logic [CW-1:0]        prev_q [4];
	logic [15:0]          want_q [4];
	logic signed [31:0]   integ_q[4];
	logic [7:0]           duty_q [4];
	logic [3:0]           run_q, pol_q;
	logic [1:0]           flags_q;
	logic                 loop_q;

	// scratch
	logic signed [DW-1:0] err_q  [4];
	logic signed [DW-1:0] coup_q [4];
	logic signed [DW-1:0] diff_q;
	logic signed [PW-1:0] prod_q;
	logic signed [AW-1:0] acc_q;

	function automatic logic signed [DW-1:0] cdiff(logic [CW-1:0] a, logic [CW-1:0] b);
		logic [CW-1:0]        s;
		logic signed [XW-1:0] x;
		s = a - b;
		x = XW'(signed'(s));
		if (x > LIM_X) return LIM;
		else if (x < -LIM_X) return -LIM;
		else return x[DW-1:0];
	endfunction

	function automatic logic positive(logic [CW-1:0] v);
		return !v[CW-1] && (|v);
	endfunction

	logic [1:0]           w;
	logic [7:0]           off;
	logic signed [DW-1:0] a_op;
	logic [15:0]          b_op;
	logic signed [EW-1:0] err_raw;
	logic [CW-1:0]        load_cnt;
	logic [15:0]          top;
	logic signed [AW-1:0] top_a;
	logic signed [DW-1:0] px, py;

	assign w       = cmd.wheel;
	assign off     = dz_q[8*w +: 8];
	assign top     = {8'(DUTY_MAX_C - off), 8'd0};
	assign top_a   = AW'(signed'({1'b0, top}));
	assign load_cnt = CW'({33'd0, tick_q});
	assign err_raw = EW'(signed'({1'b0, want_q[w]})) - EW'(prod_q);
	assign px      = flags_q[0] ? cdiff(rem_q[2], rem_q[0]) : '0;
	assign py      = flags_q[1] ? cdiff(rem_q[3], rem_q[1]) : '0;

	// multiplier operand select
	always_comb begin
		case (cmd.a_sel)
			fwspi_pkg::A_ERR:  a_op = err_q[w];
			fwspi_pkg::A_COUP: a_op = coup_q[w];
			default:           a_op = diff_q;
		endcase
		case (cmd.b_sel)
			fwspi_pkg::B_IG:  b_op = ig_q;
			fwspi_pkg::B_PIG: b_op = pig_q;
			fwspi_pkg::B_PG:  b_op = pg_q;
			fwspi_pkg::B_PPG: b_op = ppg_q;
			default:          b_op = rate_q;
		endcase
	end

	// difference, product and accumulator
	always_ff @(posedge clk) begin
		if (cmd.diff_en) diff_q <= cdiff(prev_q[w], rem_q[w]);
		if (cmd.mul_en) prod_q <= PW'(a_op) * PW'(signed'({1'b0, b_op}));
		case (cmd.acc_op)
			fwspi_pkg::ACC_INTEG:  acc_q <= AW'(integ_q[w]) + AW'(prod_q);
			fwspi_pkg::ACC_OFFSET: acc_q <= AW'(signed'({1'b0, off, 8'd0}))
				+ AW'(integ_q[w]) + AW'(prod_q);
			fwspi_pkg::ACC_ADD:    acc_q <= acc_q + AW'(prod_q);
			default: ;
		endcase
		if (cmd.wr_op == fwspi_pkg::WR_ERR) begin
			if (err_raw > LIM_E) err_q[w] <= LIM;
			else if (err_raw < -LIM_E) err_q[w] <= -LIM;
			else err_q[w] <= err_raw[DW-1:0];
		end
		if (cmd.wr_op == fwspi_pkg::WR_PAIR) begin
			coup_q[0] <= -px;
			coup_q[2] <= px;
			coup_q[1] <= -py;
			coup_q[3] <= py;
		end
	end

	// item capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= fwspi_pkg::OP_EDGE;
		end else if (item_load) begin
			op_q <= operation;
		end
	end

	always_ff @(posedge clk) begin
		if (item_load) begin
			wh_q   <= wheel;
			tick_q <= tick_count;
			dir_q  <= direction;
			tgt_q  <= target_speed;
			ps_q   <= pair_straight;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_q   <= '0;
			ig_q   <= '0;
			ppg_q  <= '0;
			pig_q  <= '0;
			rate_q <= fwspi_pkg::RATE_RST;
			dz_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fwspi_pkg::REG_PROP:       pg_q   <= cfg_data[15:0];
				fwspi_pkg::REG_INTEG:      ig_q   <= cfg_data[15:0];
				fwspi_pkg::REG_PAIR_PROP:  ppg_q  <= cfg_data[15:0];
				fwspi_pkg::REG_PAIR_INTEG: pig_q  <= cfg_data[15:0];
				fwspi_pkg::REG_RATE:       rate_q <= cfg_data[15:0];
				fwspi_pkg::REG_DEAD_ZONE:  dz_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// wheel state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				rem_q[i]   <= '0;
				prev_q[i]  <= '0;
				want_q[i]  <= '0;
				integ_q[i] <= '0;
				duty_q[i]  <= '0;
			end
			run_q   <= '0;
			pol_q   <= '0;
			flags_q <= '0;
			loop_q  <= 1'b0;
		end else begin
			case (cmd.wr_op)
				fwspi_pkg::WR_ITEM: begin
					case (op_q)
						fwspi_pkg::OP_EDGE: rem_q[wh_q] <= rem_q[wh_q] - CW'(1);
						fwspi_pkg::OP_LOAD: begin
							rem_q[wh_q]  <= load_cnt;
							prev_q[wh_q] <= load_cnt;
							want_q[wh_q] <= tgt_q;
							pol_q[wh_q]  <= dir_q;
							if (positive(load_cnt)) run_q[wh_q] <= 1'b1;
							loop_q <= 1'b1;
							flags_q[wh_q[0]] <= ps_q;
						end
						fwspi_pkg::OP_BRAKE, fwspi_pkg::OP_RESET: begin
							if (op_q == fwspi_pkg::OP_RESET) begin
								rem_q[wh_q]  <= '0;
								prev_q[wh_q] <= '0;
								want_q[wh_q] <= '0;
							end
							run_q[wh_q]      <= 1'b0;
							duty_q[wh_q]     <= '0;
							integ_q[wh_q]    <= '0;
							flags_q[wh_q[0]] <= 1'b0;
						end
						fwspi_pkg::OP_STOP: begin
							loop_q  <= 1'b0;
							run_q   <= '0;
							flags_q <= '0;
							for (int i = 0; i < 4; i++) begin
								duty_q[i]  <= '0;
								integ_q[i] <= '0;
							end
						end
						fwspi_pkg::OP_START: begin
							for (int i = 0; i < 4; i++)
								if (positive(rem_q[i])) run_q[i] <= 1'b1;
							loop_q <= 1'b1;
						end
						default: ;
					endcase
				end
				fwspi_pkg::WR_ERR: prev_q[w] <= rem_q[w];
				fwspi_pkg::WR_INTEG: begin
					if (acc_q > top_a) integ_q[w] <= 32'(top_a);
					else if (acc_q < ISAT_LO) integ_q[w] <= 32'(ISAT_LO);
					else integ_q[w] <= acc_q[31:0];
				end
				fwspi_pkg::WR_DUTY: begin
					if (run_q[w]) begin
						if (positive(rem_q[w])) begin
							// zero or negative command gives zero duty
							if (acc_q[AW-1] || acc_q == '0) duty_q[w] <= '0;
							else if (acc_q >= CMD_MAX) duty_q[w] <= DUTY_MAX_C;
							else duty_q[w] <= acc_q[15:8];
						end else begin
							run_q[w]      <= 1'b0;
							duty_q[w]     <= '0;
							integ_q[w]    <= '0;
							flags_q[w[0]] <= 1'b0;
						end
					end
				end
				fwspi_pkg::WR_FINISH: begin
					if (run_q == 4'd0) begin
						for (int i = 0; i < 4; i++) begin
							rem_q[i]   <= '0;
							prev_q[i]  <= '0;
							want_q[i]  <= '0;
							integ_q[i] <= '0;
							duty_q[i]  <= '0;
						end
						flags_q <= '0;
						loop_q  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign status.op      = op_q;
	assign status.loop_en = loop_q;

	assign duty_a        = duty_q[0];
	assign duty_b        = duty_q[1];
	assign duty_c        = duty_q[2];
	assign duty_d        = duty_q[3];
	assign running_mask  = run_q;
	assign polarity_mask = pol_q & run_q;
	assign loop_active   = loop_q;

endmodule

/* rtl/four_wheel_speed_pi_controller.sv */
// ----------------------------------------------------------------------------
// four_wheel_speed_pi_controller: four-wheel PI speed controller
// Encoder countdowns, PI loops with A/C and B/D cross-coupling, PWM duties.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch  carries one operation beat (edge, control tick, load, brake, reset
//         wheel, stop all, start all); it is taken when valid and ready meet.
//  out_ch returns exactly one beat per input beat: the four duties, running
//         and polarity masks and the loop flag as they stand after the item.
//  cfg    writes gain, rate and dead-zone registers; always ready. Write only
//         while no item is in flight.
// Timing: a control tick with the loop active runs from accept to result in steps
//  (one to decode, three per wheel for speed error, one for the pair
//  differences, eight per wheel through the one shared multiplier, one to
//  finish, one to present the result); every other beat goes from decode to result.
//  One item is in work at a time, so a new beat is accepted the cycle after
//  the result beat is taken.
// Reset clears all wheel state and loads the register defaults. A stalled
//  result holds out_ch steady and keeps in_ch ready low until it is taken.
// ----------------------------------------------------------------------------
module four_wheel_speed_pi_controller #(
	parameter int COUNT_WIDTH = fwspi_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fwspi_in_if.sink      in_ch,
	fwspi_out_if.source   out_ch,
	fwspi_cfg_if.sink     cfg
);

	fwspi_pkg::cmd_t    cmd;
	fwspi_pkg::status_t status;
	logic               in_fire;

	assign in_fire   = in_ch.valid & in_ch.ready;
	assign cfg.ready = 1'b1;

	// sequencer
	fwspi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.out_ready (out_ch.ready),
		.status    (status),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	// datapath
	fwspi_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.item_load     (in_fire),
		.operation     (in_ch.operation),
		.wheel         (in_ch.wheel),
		.tick_count    (in_ch.tick_count),
		.direction     (in_ch.direction),
		.target_speed  (in_ch.target_speed),
		.pair_straight (in_ch.pair_straight),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.duty_a        (out_ch.duty_a),
		.duty_b        (out_ch.duty_b),
		.duty_c        (out_ch.duty_c),
		.duty_d        (out_ch.duty_d),
		.running_mask  (out_ch.running_mask),
		.polarity_mask (out_ch.polarity_mask),
		.loop_active   (out_ch.loop_active)
	);

endmodule
